// ===== src/gn3_pkg.sv =====
// Package for the 3D gradient noise pipeline: formats, permutation ROM and helpers.
package gn3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 24;
  localparam int NOISE_W   = 18;
  localparam int TDATA_IN_W  = 72;
  localparam int TDATA_OUT_W = 24;
  // Fraction values in [-1, 1] with FRAC_BITS fraction bits, plus sign and guard.
  localparam int FW = FRAC_BITS + 2;
  // Blend values: dot products reach +-2, blends stay within that span.
  localparam int VW = FRAC_BITS + 4;

  localparam logic signed [NOISE_W-1:0] NOISE_MAX = {1'b0, {(NOISE_W-1){1'b1}}};
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = {1'b1, {(NOISE_W-1){1'b0}}};

  typedef logic [7:0] byte_t;

  localparam byte_t PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
    8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
    8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
    8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
    8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
    8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
    8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
    8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
    8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // Gradient dot product of the 12-direction improved noise set.
  function automatic logic signed [VW-1:0] grad_dot(input logic [3:0] h,
      input logic signed [FW-1:0] x, input logic signed [FW-1:0] y,
      input logic signed [FW-1:0] z);
    logic signed [VW-1:0] u;
    logic signed [VW-1:0] v;
    u = (h < 4'd8) ? VW'(x) : VW'(y);
    if (h < 4'd4) v = VW'(y);
    else if (h == 4'd12 || h == 4'd14) v = VW'(x);
    else v = VW'(z);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

endpackage

// ===== src/gradient_noise_3d_top.sv =====
// Top level of the 3D improved gradient noise pipeline.
//  channel  dir  tdata fields (low bit up)          handshake
//  s_axis   in   px[23:0] py[47:24] pz[71:48]       tvalid/tready
//  m_axis   out  noise[17:0], zero filled to 24     tvalid/tready
// One word per cycle is accepted while the output is not stalled; the pipe is
// the five hash lookup stages plus the dot, three blend levels.
// rst clears only the stage valid bits. The whole pipe advances together when
// the output stage is empty or taken, so a stall freezes every stage.
module gradient_noise_3d_top import gn3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // px, py, pz
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata   // noise
);
  localparam int DEPTH = 9;

  logic [DEPTH-1:0] vld;
  logic en;
  logic [COORD_W-1:0] px, py, pz;
  logic [FRAC_BITS-1:0] fx [5];
  logic [FRAC_BITS-1:0] fy [5];
  logic [FRAC_BITS-1:0] fz [5];
  logic [FW-1:0] u0, v0, w0, u, v, w;
  logic [3:0] h [8];
  logic signed [NOISE_W-1:0] noise;

  assign en = !vld[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign m_axis_tvalid = vld[DEPTH-1];
  assign m_axis_tdata = TDATA_OUT_W'({{(TDATA_OUT_W-NOISE_W){1'b0}}, noise});

  assign px = s_axis_tdata[COORD_W-1:0];
  assign py = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign pz = s_axis_tdata[3*COORD_W-1:2*COORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Fractions and fades travel alongside the five-stage hash.
  always_ff @(posedge clk) begin
    if (en) begin
      fx[0] <= px[FRAC_BITS-1:0];
      fy[0] <= py[FRAC_BITS-1:0];
      fz[0] <= pz[FRAC_BITS-1:0];
      for (int i = 1; i < 5; i++) begin
        fx[i] <= fx[i-1];
        fy[i] <= fy[i-1];
        fz[i] <= fz[i-1];
      end
      u <= u0;
      v <= v0;
      w <= w0;
    end
  end

  gn3_fade fade_x (.clk, .en, .t(px[FRAC_BITS-1:0]), .fade(u0));
  gn3_fade fade_y (.clk, .en, .t(py[FRAC_BITS-1:0]), .fade(v0));
  gn3_fade fade_z (.clk, .en, .t(pz[FRAC_BITS-1:0]), .fade(w0));

  gn3_hash hash (.clk, .en,
    .xi(px[FRAC_BITS+7:FRAC_BITS]), .yi(py[FRAC_BITS+7:FRAC_BITS]),
    .zi(pz[FRAC_BITS+7:FRAC_BITS]), .h);

  gn3_blend blend (.clk, .en, .h, .x(fx[4]), .y(fy[4]), .z(fz[4]),
    .u, .v, .w, .noise);

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");
  a_pad: assert property (@(posedge clk)
    m_axis_tdata[TDATA_OUT_W-1:NOISE_W] == '0)
    else $error("output padding not zero");
`endif
endmodule

// ===== src/gn3_fade.sv =====
// Pipelined fade curve 6t^6 - 15t^5 + 10t^4, five register stages.
module gn3_fade import gn3_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FW-1:0]        fade
);
  localparam int PW = 2 * (FRAC_BITS + 4);
  // The 6t - 15 term reaches -15 and the 10 + t*a term reaches 10, so the
  // intermediates need room for about +-16.
  localparam int IW = FW + 4;
  localparam logic signed [IW-1:0] ONE = IW'(1) <<< FRAC_BITS;

  logic signed [IW-1:0] t1, a1;
  logic signed [IW-1:0] t2, b2, sq2;
  logic signed [IW-1:0] c3, cube3;
  logic signed [IW-1:0] c4, cube4;
  logic signed [PW-1:0] p_ta, p_tb, p_tt, p_sqt, p_fc;

  assign p_ta  = PW'(t1) * PW'(a1);
  assign p_tt  = PW'(t1) * PW'(t1);
  assign p_tb  = PW'(t2) * PW'(b2);
  assign p_sqt = PW'(sq2) * PW'(t2);
  assign p_fc  = PW'(cube4) * PW'(c4);

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= IW'({1'b0, t});
      a1 <= 6 * IW'({1'b0, t}) - 15 * ONE;
      t2 <= t1;
      b2 <= IW'(p_ta >>> FRAC_BITS) + 10 * ONE;
      sq2 <= IW'(p_tt >>> FRAC_BITS);
      c3 <= IW'(p_tb >>> FRAC_BITS);
      cube3 <= IW'(p_sqt >>> FRAC_BITS);
      c4 <= c3;
      cube4 <= cube3;
      fade <= FW'(p_fc >>> FRAC_BITS);
    end
  end
endmodule

// ===== src/gn3_hash.sv =====
// Pipelined corner hashing through the permutation ROM, five lookup stages.
module gn3_hash import gn3_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  byte_t      xi,
  input  byte_t      yi,
  input  byte_t      zi,
  output logic [3:0] h [8]
);
  byte_t a, b, y1, z1, z2, aa, ab, ba, bb;
  byte_t pa, pb, pc, pd;
  logic [3:0] hq [8];

  always_ff @(posedge clk) begin
    if (en) begin
      a  <= PERM[xi];
      b  <= PERM[xi + 8'd1];
      y1 <= yi;
      z1 <= zi;
      // Index sums wrap modulo 256 through the byte width.
      pa <= PERM[a + y1];
      pb <= PERM[a + y1 + 8'd1];
      pc <= PERM[b + y1];
      pd <= PERM[b + y1 + 8'd1];
      z2 <= z1;
      aa <= pa + z2;
      ab <= pb + z2;
      ba <= pc + z2;
      bb <= pd + z2;
      hq[0] <= PERM[aa][3:0];
      hq[1] <= PERM[ba][3:0];
      hq[2] <= PERM[ab][3:0];
      hq[3] <= PERM[bb][3:0];
      hq[4] <= PERM[aa + 8'd1][3:0];
      hq[5] <= PERM[ba + 8'd1][3:0];
      hq[6] <= PERM[ab + 8'd1][3:0];
      hq[7] <= PERM[bb + 8'd1][3:0];
      // The last stage lines the codes up with the fractions and fades.
      h <= hq;
    end
  end
endmodule

// ===== src/gn3_blend.sv =====
// Gradient dot products and the three blend levels with final saturation.
module gn3_blend import gn3_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic [3:0]                 h [8],
  input  logic [FRAC_BITS-1:0]       x,
  input  logic [FRAC_BITS-1:0]       y,
  input  logic [FRAC_BITS-1:0]       z,
  input  logic [FW-1:0]              u,
  input  logic [FW-1:0]              v,
  input  logic [FW-1:0]              w,
  output logic signed [NOISE_W-1:0]  noise
);
  localparam int PW = FW + VW + 2;
  localparam logic signed [FW-1:0] ONE = FW'(1) <<< FRAC_BITS;

  logic signed [FW-1:0] xs, ys, zs, xm, ym, zm;
  logic signed [VW-1:0] g [8];
  logic signed [VW-1:0] l1 [4];
  logic signed [VW-1:0] l2 [2];
  logic signed [VW-1:0] r3;
  logic signed [FW-1:0] v1, w1, w2;

  assign xs = FW'({2'b00, x});
  assign ys = FW'({2'b00, y});
  assign zs = FW'({2'b00, z});
  assign xm = xs - ONE;
  assign ym = ys - ONE;
  assign zm = zs - ONE;

  function automatic logic signed [VW-1:0] lerp(input logic signed [FW-1:0] s,
      input logic signed [VW-1:0] a0, input logic signed [VW-1:0] b0);
    logic signed [PW-1:0] p;
    p = PW'(s) * (PW'(b0) - PW'(a0));
    return a0 + VW'(p >>> FRAC_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      g[0] <= grad_dot(h[0], xs, ys, zs);
      g[1] <= grad_dot(h[1], xm, ys, zs);
      g[2] <= grad_dot(h[2], xs, ym, zs);
      g[3] <= grad_dot(h[3], xm, ym, zs);
      g[4] <= grad_dot(h[4], xs, ys, zm);
      g[5] <= grad_dot(h[5], xm, ys, zm);
      g[6] <= grad_dot(h[6], xs, ym, zm);
      g[7] <= grad_dot(h[7], xm, ym, zm);
      for (int i = 0; i < 4; i++) l1[i] <= lerp(u, g[2*i], g[2*i+1]);
      v1 <= v;
      w1 <= w;
      l2[0] <= lerp(v1, l1[0], l1[1]);
      l2[1] <= lerp(v1, l1[2], l1[3]);
      w2 <= w1;
      r3 <= lerp(w2, l2[0], l2[1]);
    end
  end

  always_comb begin
    if (r3 > VW'(NOISE_MAX)) noise = NOISE_MAX;
    else if (r3 < VW'(NOISE_MIN)) noise = NOISE_MIN;
    else noise = NOISE_W'(r3);
  end
endmodule

// ===== bench/gradient_noise_3d_top_tb.sv =====
// Self-checking bench for the 3D gradient noise pipeline with random stream stalls.
module gradient_noise_3d_top_tb;
  import gn3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1500;

  typedef struct packed {
    logic [COORD_W-1:0] pz;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] px;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;

  point_t pending_points[$];
  logic [NOISE_W-1:0] expected_noise[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  always #4 clk = ~clk;

  gradient_noise_3d_top dut (.*);

  // Products drop FRAC_BITS bits, rounding toward minus infinity.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint fade(longint t);
    longint one, a, b, c, t2, t3;
    one = longint'(1) << FRAC_BITS;
    a = 6 * t - 15 * one;
    b = qmul(t, a) + 10 * one;
    c = qmul(t, b);
    t2 = qmul(t, t);
    t3 = qmul(t2, t);
    return qmul(t3, c);
  endfunction

  function automatic longint lerp(longint s, longint a, longint b);
    return a + qmul(s, b - a);
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic logic [NOISE_W-1:0] noise_at(point_t p);
    longint one, x, y, z, u, v, w, n0, n1, r;
    logic [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
    one = longint'(1) << FRAC_BITS;
    cx = p.px[FRAC_BITS +: 8];
    cy = p.py[FRAC_BITS +: 8];
    cz = p.pz[FRAC_BITS +: 8];
    x = longint'(p.px[FRAC_BITS-1:0]);
    y = longint'(p.py[FRAC_BITS-1:0]);
    z = longint'(p.pz[FRAC_BITS-1:0]);
    u = fade(x);
    v = fade(y);
    w = fade(z);
    // All hash sums wrap in 8 bits.
    a = PERM[cx] + cy;
    aa = PERM[a] + cz;
    ab = PERM[8'(a + 1)] + cz;
    b = PERM[8'(cx + 1)] + cy;
    ba = PERM[b] + cz;
    bb = PERM[8'(b + 1)] + cz;
    n0 = lerp(v, lerp(u, corner_dot(PERM[aa], x, y, z), corner_dot(PERM[ba], x - one, y, z)),
              lerp(u, corner_dot(PERM[ab], x, y - one, z),
                   corner_dot(PERM[bb], x - one, y - one, z)));
    n1 = lerp(v, lerp(u, corner_dot(PERM[8'(aa + 1)], x, y, z - one),
                      corner_dot(PERM[8'(ba + 1)], x - one, y, z - one)),
              lerp(u, corner_dot(PERM[8'(ab + 1)], x, y - one, z - one),
                   corner_dot(PERM[8'(bb + 1)], x - one, y - one, z - one)));
    r = lerp(w, n0, n1);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[NOISE_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {8'($urandom), {FRAC_BITS{1'b0}}};
      3: return {8'($urandom), {FRAC_BITS{1'b1}}};
      default: return COORD_W'($urandom);
    endcase
  endfunction

  initial begin
    point_t p;
    logic [COORD_W-1:0] edge_vals[6];
    edge_vals = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFF0000, 24'h008000, 24'h7F4000};
    for (int i = 0; i < 6; i++) begin
      p.px = edge_vals[i];
      p.py = edge_vals[(i + 1) % 6];
      p.pz = edge_vals[(i + 3) % 6];
      pending_points.push_back(p);
    end
    // Sweep the cell bits with fixed fractions.
    for (int i = 0; i < 16; i++) begin
      p.px = {8'(i * 17), 16'h4000};
      p.py = {8'(i * 5), 16'hC000};
      p.pz = {8'(255 - i), 16'h2000};
      pending_points.push_back(p);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      p.px = rand_coord();
      p.py = rand_coord();
      p.pz = rand_coord();
      pending_points.push_back(p);
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Handshakes are caught at the rising edge, where they take effect.
  always @(posedge clk) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
    out_taken <= m_axis_tvalid && m_axis_tready;
  end

  int send_wait = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        expected_noise.push_back(noise_at(point_t'(s_axis_tdata)));
        send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end
      if (s_axis_tvalid && !in_taken) begin
        // Hold the word until it is taken.
      end else if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        s_axis_tdata <= pending_points.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
        stimulus_done = 1'b1;
      end
    end
  end

  int recv_wait = 0;
  always @(negedge clk) begin
    if (out_taken)
      recv_wait = $urandom_range(0, 3);
    if (recv_wait > 0) begin
      recv_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst;
    end
  end

  always @(posedge clk) begin
    logic [NOISE_W-1:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_noise.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected word: noise=%0h", m_axis_tdata);
        end else begin
          want = expected_noise.pop_front();
          if (m_axis_tdata !== {{(TDATA_OUT_W-NOISE_W){1'b0}}, want}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Noise mismatch: expected %0h actual %0h", want, m_axis_tdata);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fork
      begin
        wait (stimulus_done && expected_noise.size() == 0);
        repeat (20) @(posedge clk);
      end
      wait (idle_cycles >= WATCHDOG_LIMIT);
    join_any
    if (idle_cycles < WATCHDOG_LIMIT && mismatches == 0 && expected_noise.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
